[hdl/tdpcm_pkg.sv]
// ----------------------------------------------------------------------------
// Table DPCM decoder package
// Step table, configuration register indexes and shared types.
// ----------------------------------------------------------------------------
package tdpcm_pkg;

    typedef logic [14:0] t_step;
    typedef logic [1:0]  t_cfg_index;

    localparam t_cfg_index CFG_CHANNEL_COUNT = 2'd0;
    localparam t_cfg_index CFG_CHUNK_SAMPLES = 2'd1;
    localparam t_cfg_index CFG_SIXTEEN_BIT   = 2'd2;

    localparam int STEP_COUNT = 128;

    localparam t_step STEP_TABLE [STEP_COUNT] = '{
        15'h000, 15'h008, 15'h010, 15'h020, 15'h030, 15'h040, 15'h050, 15'h060,
        15'h070, 15'h080, 15'h090, 15'h0A0, 15'h0B0, 15'h0C0, 15'h0D0, 15'h0E0,
        15'h0F0, 15'h100, 15'h110, 15'h120, 15'h130, 15'h140, 15'h150, 15'h160,
        15'h170, 15'h180, 15'h190, 15'h1A0, 15'h1B0, 15'h1C0, 15'h1D0, 15'h1E0,
        15'h1F0, 15'h200, 15'h208, 15'h210, 15'h218, 15'h220, 15'h228, 15'h230,
        15'h238, 15'h240, 15'h248, 15'h250, 15'h258, 15'h260, 15'h268, 15'h270,
        15'h278, 15'h280, 15'h288, 15'h290, 15'h298, 15'h2A0, 15'h2A8, 15'h2B0,
        15'h2B8, 15'h2C0, 15'h2C8, 15'h2D0, 15'h2D8, 15'h2E0, 15'h2E8, 15'h2F0,
        15'h2F8, 15'h300, 15'h308, 15'h310, 15'h318, 15'h320, 15'h328, 15'h330,
        15'h338, 15'h340, 15'h348, 15'h350, 15'h358, 15'h360, 15'h368, 15'h370,
        15'h378, 15'h380, 15'h388, 15'h390, 15'h398, 15'h3A0, 15'h3A8, 15'h3B0,
        15'h3B8, 15'h3C0, 15'h3C8, 15'h3D0, 15'h3D8, 15'h3E0, 15'h3E8, 15'h3F0,
        15'h3F8, 15'h400, 15'h440, 15'h480, 15'h4C0, 15'h500, 15'h540, 15'h580,
        15'h5C0, 15'h600, 15'h640, 15'h680, 15'h6C0, 15'h700, 15'h740, 15'h780,
        15'h7C0, 15'h800, 15'h900, 15'hA00, 15'hB00, 15'hC00, 15'hD00, 15'hE00,
        15'hF00, 15'h1000, 15'h1400, 15'h1800, 15'h1C00, 15'h2000, 15'h3000,
        15'h4000
    };

endpackage

[hdl/table_dpcm_audio_chunk_decoder.sv]
// ----------------------------------------------------------------------------
// Table DPCM audio chunk decoder
// Decodes audio chunks into 16-bit samples, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
// The decoder accepts one byte every clock cycle while the output side keeps
// up. A byte waits in the input register; the step lookup, add and clip are
// combinational up to the result register, so its sample is presented in the
// cycle after the transfer. A stalled output holds the input register and
// stops the byte stream. In 16-bit mode each chunk starts with one raw
// little-endian sample per channel; the low byte of each is only latched and
// gives no output, so a chunk of as many bytes as the chunk sample count plus
// one per channel yields that many samples. In 8-bit mode each byte comes out
// unchanged. The configuration must be written only while no byte is in
// flight, and the feeder must deliver whole chunks; the block enforces neither.
module table_dpcm_audio_chunk_decoder
    import tdpcm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  t_cfg_index         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample,
    output logic               o_channel,
    output logic               o_chunk_end
);

    // Configuration.
    logic [1:0]  r_channel_count;
    logic [15:0] r_chunk_samples;
    logic        r_sixteen_bit;

    // Decode state.
    logic signed [15:0] r_pred [2];
    logic [16:0]        r_pos;
    logic [7:0]         r_low_byte;
    logic               r_cur_ch;

    // Input register and result register.
    logic               r_in_vld;
    logic [7:0]         r_in_byte;
    logic               r_out_vld;
    logic signed [15:0] r_out_sample;
    logic               r_out_ch;
    logic               r_out_end;

    logic               adv;
    logic               stereo;
    logic [2:0]         hdr_len;
    logic [16:0]        total16;
    logic [16:0]        total;
    logic               last;
    logic               is_hdr;
    logic               hdr_low;
    logic               ch_sel;
    logic signed [15:0] pred_cur;
    t_step              step;
    logic signed [17:0] sum;
    logic signed [15:0] clipped;
    logic signed [15:0] n_sample;
    logic               n_ch;
    logic               n_cur_ch;

    assign o_cfg_ready = 1'b1;
    assign adv         = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || adv;

    assign stereo  = r_channel_count[1];
    assign hdr_len = stereo ? 3'd4 : 3'd2;

    always_comb begin
        total16 = {1'b0, r_chunk_samples} + (stereo ? 17'd2 : 17'd1);
        if (r_sixteen_bit) begin
            total = (total16 < {14'd0, hdr_len}) ? {14'd0, hdr_len} : total16;
        end else begin
            total = (r_chunk_samples == 16'd0) ? 17'd1 : {1'b0, r_chunk_samples};
        end
    end

    assign last    = r_pos >= (total - 17'd1);
    assign is_hdr  = r_sixteen_bit && (r_pos < {14'd0, hdr_len});
    assign hdr_low = is_hdr && !r_pos[0];

    assign ch_sel   = is_hdr ? r_pos[1] : r_cur_ch;
    assign pred_cur = r_pred[ch_sel];
    assign step     = STEP_TABLE[r_in_byte[6:0]];

    always_comb begin
        if (r_in_byte[7]) begin
            sum = {{2{pred_cur[15]}}, pred_cur} - {3'd0, step};
        end else begin
            sum = {{2{pred_cur[15]}}, pred_cur} + {3'd0, step};
        end
        if (!sum[17] && (sum[16:15] != 2'b00)) begin
            clipped = 16'sh7FFF;
        end else if (sum[17] && (sum[16:15] != 2'b11)) begin
            clipped = -16'sh8000;
        end else begin
            clipped = sum[15:0];
        end
    end

    always_comb begin
        n_ch = ch_sel;
        if (is_hdr) begin
            n_sample = {r_in_byte, r_low_byte};
            n_cur_ch = 1'b0;
        end else if (r_sixteen_bit) begin
            n_sample = clipped;
            n_cur_ch = stereo ? !r_cur_ch : 1'b0;
        end else begin
            n_sample = {8'd0, r_in_byte};
            n_cur_ch = stereo ? !r_cur_ch : 1'b0;
        end
        if (last) begin
            n_cur_ch = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= 2'd1;
            r_chunk_samples <= 16'd1;
            r_sixteen_bit   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[1:0];
                CFG_CHUNK_SAMPLES: r_chunk_samples <= i_cfg_data;
                CFG_SIXTEEN_BIT:   r_sixteen_bit   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred[0]  <= '0;
            r_pred[1]  <= '0;
            r_pos      <= '0;
            r_low_byte <= '0;
            r_cur_ch   <= 1'b0;
        end else if (adv) begin
            if (hdr_low) begin
                r_low_byte <= r_in_byte;
                r_pos      <= r_pos + 17'd1;
            end else begin
                if (r_sixteen_bit) begin
                    r_pred[ch_sel] <= n_sample;
                end
                r_cur_ch <= n_cur_ch;
                r_pos    <= last ? 17'd0 : r_pos + 17'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= !hdr_low;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (adv && !hdr_low) begin
            r_out_sample <= n_sample;
            r_out_ch     <= n_ch;
            r_out_end    <= last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_sample    = r_out_sample;
    assign o_channel   = r_out_ch;
    assign o_chunk_end = r_out_end;

    // A header low byte only moves the position on.
    a_hdr_low_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && hdr_low |=> !r_out_vld && r_pos == $past(r_pos) + 17'd1)
        else $error("header low byte produced a result or lost its position");

    // The last byte of a chunk restarts position and channel.
    a_chunk_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !hdr_low && last |=> r_pos == 17'd0 && !r_cur_ch && r_out_end)
        else $error("chunk end did not restart the chunk");

    // A result that is not taken stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_ready |=> r_out_vld && $stable(r_out_sample)
            && $stable(r_out_ch) && $stable(r_out_end))
        else $error("result changed while stalled");

    // A held input byte is not overwritten before it is decoded.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld && $stable(r_in_byte))
        else $error("input register overwritten while stalled");

endmodule
